FILE: hdl/pidc_pkg.sv
// Shared types and constants for the PID position controller.
// No dependencies; imported by every module of the block.
package pidc_pkg;

  localparam int ADC_MAX        = 4095;
  localparam int GAIN_SCALE     = 100;
  localparam int DRIVE_LIMIT    = 4095;
  localparam int INTEGRAL_LIMIT = 20000;

  localparam int POS_W   = 12;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 13;
  localparam int INTEG_W = 16;
  localparam int DERIV_W = 14;
  localparam int SUM_W   = 32;
  localparam int IDX_W   = 8;
  localparam int DATA_W  = 16;

  // Magnitude at which the scaled drive saturates, and the reciprocal of 100.
  localparam int MAG_W       = 19;
  localparam int MAG_LIMIT   = (DRIVE_LIMIT + 1) * GAIN_SCALE - 1;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;
  localparam int QUOT_W      = 12;

  localparam logic [IDX_W-1:0] REG_TARGET = 8'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P = 8'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I = 8'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D = 8'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  target;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } err_word_t;

endpackage

FILE: hdl/pidc_cfg.sv
// Configuration register file: setpoint and the three gains.
// Depends on pidc_pkg.
module pidc_cfg import pidc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output cfg_t              cfg
);

  cfg_t             cfg_r, cfg_nxt;
  logic [POS_W-1:0] target_sat;

  localparam logic [DATA_W-1:0] ADC_MAX_W = DATA_W'(ADC_MAX);

  always_comb begin
    if ({{(DATA_W-POS_W){1'b0}}, cfg_data[POS_W-1:0]} > ADC_MAX_W) begin
      target_sat = ADC_MAX_W[POS_W-1:0];
    end else begin
      target_sat = cfg_data[POS_W-1:0];
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET: cfg_nxt.target = target_sat;
        REG_GAIN_P: cfg_nxt.kp     = cfg_data[GAIN_W-1:0];
        REG_GAIN_I: cfg_nxt.ki     = cfg_data[GAIN_W-1:0];
        REG_GAIN_D: cfg_nxt.kd     = cfg_data[GAIN_W-1:0];
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/pidc_err.sv
// Error stage: error, clamped integral and derivative; holds the loop state.
// Depends on pidc_pkg.
module pidc_err import pidc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             accept,
  input  logic             opcode,
  input  logic [POS_W-1:0] position,
  input  logic [POS_W-1:0] target,
  output logic             valid,
  output err_word_t        word
);

  localparam logic signed [INTEG_W:0] ILIM_P = (INTEG_W+1)'(INTEGRAL_LIMIT);
  localparam logic signed [INTEG_W:0] ILIM_N = -ILIM_P;

  logic signed [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic                      valid_r, valid_nxt;
  err_word_t                 word_r, word_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_clamp;

  always_comb begin
    err       = $signed({1'b0, target}) - $signed({1'b0, position});
    integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err);
    if (integ_sum > ILIM_P) begin
      integ_clamp = ILIM_P[INTEG_W-1:0];
    end else if (integ_sum < ILIM_N) begin
      integ_clamp = ILIM_N[INTEG_W-1:0];
    end else begin
      integ_clamp = integ_sum[INTEG_W-1:0];
    end

    last_err_nxt   = last_err_r;
    integ_nxt      = integ_r;
    valid_nxt      = 1'b0;
    word_nxt.err   = err;
    word_nxt.integ = integ_clamp;
    word_nxt.deriv = DERIV_W'(err) - DERIV_W'(last_err_r);
    if (accept) begin
      if (opcode == OP_CLEAR) begin
        integ_nxt = '0;
      end else begin
        integ_nxt    = integ_clamp;
        last_err_nxt = err;
        valid_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
      valid_r    <= 1'b0;
    end else begin
      last_err_r <= last_err_nxt;
      integ_r    <= integ_nxt;
      if (en) begin
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid = valid_r;
  assign word  = word_r;

endmodule

FILE: hdl/pidc_mac.sv
// Gain stage: the three gain products summed into one 32-bit word.
// Depends on pidc_pkg.
module pidc_mac import pidc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  err_word_t               word,
  input  cfg_t                    cfg,
  output logic                    valid,
  output logic signed [SUM_W-1:0] sum,
  output logic signed [ERR_W-1:0] err
);

  logic signed [SUM_W+1:0] p_term, i_term, d_term, total;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ERR_W-1:0] err_r;
  logic                    valid_r;

  always_comb begin
    p_term = (SUM_W+2)'($signed({1'b0, cfg.kp})) * (SUM_W+2)'(word.err);
    i_term = (SUM_W+2)'($signed({1'b0, cfg.ki})) * (SUM_W+2)'(word.integ);
    d_term = (SUM_W+2)'($signed({1'b0, cfg.kd})) * (SUM_W+2)'(word.deriv);
    total  = p_term + i_term + d_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= total[SUM_W-1:0];
      err_r <= word.err;
    end
  end

  assign valid = valid_r;
  assign sum   = sum_r;
  assign err   = err_r;

endmodule

FILE: hdl/pidc_out.sv
// Output stage: divide by 100 toward zero, clamp, and the result register.
// Depends on pidc_pkg.
module pidc_out import pidc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [SUM_W-1:0] sum,
  input  logic signed [ERR_W-1:0] err,
  output logic                    valid,
  output logic signed [ERR_W-1:0] drive,
  output logic signed [ERR_W-1:0] position_error
);

  localparam logic [SUM_W-1:0]   MAG_LIM_W = SUM_W'(MAG_LIMIT);
  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);

  logic                        neg;
  logic [SUM_W-1:0]            mag;
  logic [MAG_W-1:0]            mag_sat;
  logic [MAG_W+RECIP_W-1:0]    prod;
  logic [QUOT_W-1:0]           quot;
  logic signed [ERR_W-1:0]     drive_nxt, drive_r, err_r;
  logic                        valid_r;

  // magnitude is saturated first, so the quotient never exceeds the limit
  always_comb begin
    neg = sum[SUM_W-1];
    mag = neg ? SUM_W'(-sum) : SUM_W'(sum);
    if (mag > MAG_LIM_W) begin
      mag_sat = MAG_LIM_W[MAG_W-1:0];
    end else begin
      mag_sat = mag[MAG_W-1:0];
    end
    prod      = (MAG_W+RECIP_W)'(mag_sat) * (MAG_W+RECIP_W)'(RECIP_V);
    quot      = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    drive_nxt = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drive_r <= drive_nxt;
      err_r   <= err;
    end
  end

  assign valid          = valid_r;
  assign drive          = drive_r;
  assign position_error = err_r;

endmodule

FILE: hdl/pid_position_controller_core.sv
// Top level of the PID position controller.
// Depends on pidc_pkg, pidc_cfg, pidc_err, pidc_mac and pidc_out.
//
// Usage:
//   Input channel (in_valid/in_stall): one word per item, in_opcode selects
//   a position sample or a clear of the integral. A clear updates state only
//   and produces no output word.
//   Output channel (out_valid/out_stall): drive and position_error for each
//   sample.
//   Config port: cfg_wr_en/cfg_index/cfg_data, index 0 setpoint (cfg_data[11:0],
//   at most ADC_MAX), 1..3 the P, I and D gains; other indexes are ignored.
//   Write only while the pipeline is empty.
// Timing:
//   Three-stage pipeline (error/integral, gain products, divide and clamp).
//   An accepted sample passes the error, gain and output registers in order.
//   One word per cycle unless stalled; the loop state updates on the accepting edge.
// Reset (rst_n low, synchronous): gains, setpoint, integral, last error and
//   all valid flags clear.
// Stall: while out_stall holds a pending output, every stage freezes and
//   in_stall is raised; nothing is dropped.
module pid_position_controller_core import pidc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ERR_W-1:0] out_drive,
  output logic signed [ERR_W-1:0] out_position_error,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]       cfg_data
);

  cfg_t                    cfg;
  err_word_t               e_word;
  logic                    e_vld, m_vld;
  logic signed [SUM_W-1:0] m_sum;
  logic signed [ERR_W-1:0] m_err;
  logic                    en, accept;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  pidc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_err u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .accept   (accept),
    .opcode   (in_opcode),
    .position (in_position),
    .target   (cfg.target),
    .valid    (e_vld),
    .word     (e_word)
  );

  pidc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (e_vld),
    .word   (e_word),
    .cfg    (cfg),
    .valid  (m_vld),
    .sum    (m_sum),
    .err    (m_err)
  );

  pidc_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_vld         (m_vld),
    .sum            (m_sum),
    .err            (m_err),
    .valid          (out_valid),
    .drive          (out_drive),
    .position_error (out_position_error)
  );

endmodule
